### src/dlpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dlpg_pkg;

    localparam int COORD_BITS  = 12;
    localparam int FWIDTH_BITS = 13;
    localparam int ADDR_BITS   = 24;
    localparam int COLOR_BITS  = 32;

    localparam logic [FWIDTH_BITS-1:0] FWIDTH_RESET = 13'd640;

    // Beat kinds carried in s_axis_tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Register index taken from the word address.
    localparam logic REG_FRAME_WIDTH = 1'b0;

    typedef logic [COORD_BITS-1:0]  coord_t;
    typedef logic [FWIDTH_BITS-1:0] fwidth_t;
    typedef logic [ADDR_BITS-1:0]   addr_t;
    typedef logic [COLOR_BITS-1:0]  color_t;

endpackage

`default_nettype wire

### src/dda_line_pixel_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Step beats: one pixel beat per cycle while the output takes each beat, registered in
// the cycle after the step is taken. Load beats: empty, vertical and horizontal lines
// need no divide; sloped lines run the restoring divider (one quotient bit per cycle),
// which holds the input off. A waiting pixel beat also holds the input off; a new step
// enters as that beat leaves. Reset (rst_n low, asynchronous) clears the line state, the
// output beat and sets frame_width to 640.
module dda_line_pixel_generator #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [11:0] x_start, [23:12] y_start, [35:24] x_end, [47:36] y_end, [79:48] line_color
    input  wire logic [79:0] s_axis_tdata,
    // [0] op
    input  wire logic        s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [23:0] pixel_address, [55:24] pixel_value
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tlast,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CB     = dlpg_pkg::COORD_BITS;
    localparam int ACC_W  = CB + FRAC_BITS;
    localparam int SLP_W  = CB + FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);
    localparam int PROD_W = CB + dlpg_pkg::FWIDTH_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic                   state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CB-1:0]          rem_reg;
    logic [FRAC_BITS:0]     quo_reg;
    dlpg_pkg::coord_t       dmaj_reg;
    logic                   neg_reg;

    dlpg_pkg::coord_t       major_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [SLP_W-1:0]       slope_reg;
    dlpg_pkg::fwidth_t      remaining_reg;
    logic                   steep_reg;
    dlpg_pkg::color_t       color_reg;
    dlpg_pkg::fwidth_t      frame_width_reg;

    logic                   out_valid_reg;
    dlpg_pkg::addr_t        out_addr_reg;
    dlpg_pkg::color_t       out_value_reg;
    logic                   out_last_reg;

    // Input fields.
    dlpg_pkg::coord_t xs, ys, xe, ye;
    dlpg_pkg::color_t in_color;
    assign xs       = s_axis_tdata[11:0];
    assign ys       = s_axis_tdata[23:12];
    assign xe       = s_axis_tdata[35:24];
    assign ye       = s_axis_tdata[47:36];
    assign in_color = s_axis_tdata[79:48];

    logic in_accept, load_accept, step_accept, out_accept, line_active;
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign load_accept   = in_accept && (s_axis_tuser == dlpg_pkg::OP_LOAD);
    assign step_accept   = in_accept && (s_axis_tuser == dlpg_pkg::OP_STEP);
    assign out_accept    = out_valid_reg && m_axis_tready;
    assign line_active   = remaining_reg != '0;

    // Line setup: classify, order the endpoints along the major axis.
    dlpg_pkg::coord_t adx, ady, ma_a, ma_b, mi_a, mi_b;
    dlpg_pkg::coord_t lo_maj, hi_maj, lo_min, hi_min, dmaj, dmin;
    logic             steep, swap, neg, empty;

    always_comb
    begin
        adx    = (xs > xe) ? xs - xe : xe - xs;
        ady    = (ys > ye) ? ys - ye : ye - ys;
        steep  = (adx == '0) || ((ady != '0) && (ady >= adx));
        ma_a   = steep ? ys : xs;
        ma_b   = steep ? ye : xe;
        mi_a   = steep ? xs : ys;
        mi_b   = steep ? xe : ye;
        swap   = ma_a > ma_b;
        lo_maj = swap ? ma_b : ma_a;
        hi_maj = swap ? ma_a : ma_b;
        lo_min = swap ? mi_b : mi_a;
        hi_min = swap ? mi_a : mi_b;
        dmaj   = hi_maj - lo_maj;
        neg    = hi_min < lo_min;
        dmin   = neg ? lo_min - hi_min : hi_min - lo_min;
        empty  = (xs == xe) && (ys == ye);
    end

    // Restoring divider step: one quotient bit per cycle. The first step
    // tests the integer bit without a shift, since the minor delta never exceeds
    // the major delta.
    logic                   div_first, div_ge, div_done;
    logic [CB:0]            div_trial;
    logic [CB-1:0]          rem_next;
    logic [FRAC_BITS:0]     quo_next;
    logic [SLP_W-1:0]       mag;

    always_comb
    begin
        div_first = cnt_reg == CNT_W'(FRAC_BITS);
        div_trial = div_first ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        div_ge    = div_trial >= {1'b0, dmaj_reg};
        rem_next  = div_ge ? CB'(div_trial - {1'b0, dmaj_reg}) : CB'(div_trial);
        quo_next  = {quo_reg[FRAC_BITS-1:0], div_ge};
        div_done  = cnt_reg == '0;
        mag       = SLP_W'(quo_next);
    end

    // Pixel address for the current step.
    dlpg_pkg::coord_t   minor, row, col;
    logic [PROD_W-1:0]  addr_sum;

    always_comb
    begin
        minor    = acc_reg[ACC_W-1:FRAC_BITS];
        row      = steep_reg ? major_reg : minor;
        col      = steep_reg ? minor : major_reg;
        addr_sum = PROD_W'(row) * PROD_W'(frame_width_reg) + PROD_W'(col);
    end

    dlpg_pkg::fwidth_t remaining_dec;
    assign remaining_dec = remaining_reg - 1'b1;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            remaining_reg   <= '0;
            out_valid_reg   <= 1'b0;
            frame_width_reg <= dlpg_pkg::FWIDTH_RESET;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && (paddr[2] == dlpg_pkg::REG_FRAME_WIDTH))
            begin
                frame_width_reg <= pwdata[dlpg_pkg::FWIDTH_BITS-1:0];
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (load_accept)
                    begin
                        remaining_reg <= empty ? '0 : dlpg_pkg::fwidth_t'(dmaj);
                        cnt_reg       <= CNT_W'(FRAC_BITS);
                        if (!empty && dmin != '0)
                        begin
                            state_reg <= ST_DIV;
                        end
                    end
                    else if (step_accept && line_active)
                    begin
                        remaining_reg <= remaining_dec;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (div_done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (step_accept && line_active)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Line and pixel payload.
    always_ff @(posedge clk)
    begin
        if (load_accept)
        begin
            color_reg <= in_color;
            rem_reg   <= dmin;
            dmaj_reg  <= dmaj;
            neg_reg   <= neg;
            quo_reg   <= '0;
            slope_reg <= '0;
            if (empty)
            begin
                steep_reg <= 1'b0;
                major_reg <= '0;
                acc_reg   <= '0;
            end
            else
            begin
                steep_reg <= steep;
                major_reg <= lo_maj;
                acc_reg   <= {lo_min, FRAC_BITS'(0)};
            end
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (div_done)
            begin
                slope_reg <= neg_reg ? SLP_W'(-mag) : mag;
            end
        end
        else if (step_accept && line_active)
        begin
            major_reg     <= major_reg + 1'b1;
            acc_reg       <= acc_reg + slope_reg[ACC_W-1:0];
            out_addr_reg  <= addr_sum[dlpg_pkg::ADDR_BITS-1:0];
            out_value_reg <= color_reg;
            out_last_reg  <= remaining_dec == '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_value_reg, out_addr_reg};
    assign m_axis_tlast  = out_last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == dlpg_pkg::REG_FRAME_WIDTH)
                    ? 32'(frame_width_reg) : 32'd0;

    // The divider owns the block until the slope is written.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> !s_axis_tready)
        else $error("input taken while the divider runs");

    // A last pixel waiting means the line is finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> remaining_reg == '0)
        else $error("last pixel shown with pixels still left");

    // A step on an active line always yields a pixel beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_accept && line_active |=> m_axis_tvalid)
        else $error("step on an active line produced no pixel");

    // A step with no line active yields nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_accept && !line_active |=> !m_axis_tvalid)
        else $error("pixel produced with no line active");

endmodule

`default_nettype wire

### tb/sv/dda_line_pixel_generator_tb.sv
`timescale 1ns / 1ps

module dda_line_pixel_generator_tb;

    localparam int FRAC  = 16;
    localparam int ACC_W = dlpg_pkg::COORD_BITS + FRAC;

    typedef struct packed {
        dlpg_pkg::addr_t  addr;
        dlpg_pkg::color_t value;
        logic             last;
    } pixel_t;

    // Line walker state plus the queue of pixel writes still owed by the block.
    class pixel_scoreboard;
        dlpg_pkg::fwidth_t frame_width;
        dlpg_pkg::coord_t  major_pos;
        logic [ACC_W-1:0]  minor_acc;
        logic [ACC_W:0]    minor_step;
        dlpg_pkg::fwidth_t remaining;
        logic              steep;
        dlpg_pkg::color_t  color;
        pixel_t            pending_pixels[$];
        int                errors;

        function new();
            frame_width = dlpg_pkg::FWIDTH_RESET;
            major_pos   = '0;
            minor_acc   = '0;
            minor_step  = '0;
            remaining   = '0;
            steep       = 1'b0;
            color       = '0;
            errors      = 0;
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function void take_beat(logic op, dlpg_pkg::coord_t xs, dlpg_pkg::coord_t ys,
                                dlpg_pkg::coord_t xe, dlpg_pkg::coord_t ye,
                                dlpg_pkg::color_t line_color);
            dlpg_pkg::coord_t adx, ady, ma_a, ma_b, mi_a, mi_b, swap, dmaj, diff;
            dlpg_pkg::coord_t minor, row, col;
            logic             neg;
            logic [ACC_W-1:0] mag;
            logic [31:0]      lin;
            pixel_t           px;

            if (op == dlpg_pkg::OP_LOAD) begin
                color = line_color;
                if (xs == xe && ys == ye) begin
                    remaining  = '0;
                    steep      = 1'b0;
                    major_pos  = '0;
                    minor_acc  = '0;
                    minor_step = '0;
                    return;
                end
                adx   = (xs > xe) ? xs - xe : xe - xs;
                ady   = (ys > ye) ? ys - ye : ye - ys;
                steep = (adx == 0) || (ady != 0 && ady >= adx);
                if (steep) begin
                    ma_a = ys; ma_b = ye; mi_a = xs; mi_b = xe;
                end else begin
                    ma_a = xs; ma_b = xe; mi_a = ys; mi_b = ye;
                end
                // The run always starts at the lower major coordinate.
                if (ma_a > ma_b) begin
                    swap = ma_a; ma_a = ma_b; ma_b = swap;
                    swap = mi_a; mi_a = mi_b; mi_b = swap;
                end
                dmaj       = ma_b - ma_a;
                neg        = mi_b < mi_a;
                diff       = neg ? mi_a - mi_b : mi_b - mi_a;
                mag        = {diff, {FRAC{1'b0}}} / ACC_W'(dmaj);
                minor_step = neg ? (ACC_W+1)'(0) - (ACC_W+1)'(mag) : (ACC_W+1)'(mag);
                major_pos  = ma_a;
                minor_acc  = {mi_a, {FRAC{1'b0}}};
                remaining  = dlpg_pkg::fwidth_t'(dmaj);
                return;
            end
            if (remaining == 0)
                return;
            minor = minor_acc[ACC_W-1:FRAC];
            if (steep) begin
                row = major_pos;
                col = minor;
            end else begin
                row = minor;
                col = major_pos;
            end
            lin       = 32'(row) * 32'(frame_width) + 32'(col);
            remaining = remaining - 1'b1;
            px.addr   = lin[dlpg_pkg::ADDR_BITS-1:0];
            px.value  = color;
            px.last   = (remaining == 0);
            pending_pixels.push_back(px);
            major_pos = major_pos + 1'b1;
            minor_acc = minor_acc + minor_step[ACC_W-1:0];
        endfunction

        function void check_pixel(dlpg_pkg::addr_t addr, dlpg_pkg::color_t value,
                                  logic last);
            pixel_t want;

            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel beat addr=%h value=%h last=%b",
                         $time, addr, value, last);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (addr !== want.addr) begin
                $display("%0t: pixel_address expected %h actual %h", $time, want.addr, addr);
                errors++;
            end
            if (value !== want.value) begin
                $display("%0t: pixel_value expected %h actual %h", $time, want.value, value);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last_pixel expected %b actual %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pixel_scoreboard sb = new();

    logic idle_en;
    logic hold_req;

    dda_line_pixel_generator #(
        .FRAC_BITS(FRAC)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("dda_line_pixel_generator: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata[23:0], m_axis_tdata[55:24], m_axis_tlast);
    end

    // Pixel sink: random ready bursts, plus one long hold-off on request so the
    // block backs up and stalls its input.
    initial
    begin : pixel_sink
        int stall_left;
        int free_left;
        logic nxt;

        stall_left = 0;
        free_left  = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = 300;
                free_left  = 0;
            end
            if (stall_left == 0 && free_left == 0)
            begin
                if (idle_en && $urandom_range(0, 2) == 0)
                    stall_left = $urandom_range(1, 14);
                else
                    free_left = $urandom_range(1, 30);
            end
            if (stall_left > 0)
            begin
                nxt = 1'b0;
                stall_left--;
            end
            else
            begin
                nxt = 1'b1;
                free_left--;
            end
            m_axis_tready = nxt;
        end
    end

    task automatic send_beat(logic op, dlpg_pkg::coord_t xs, dlpg_pkg::coord_t ys,
                             dlpg_pkg::coord_t xe, dlpg_pkg::coord_t ye,
                             dlpg_pkg::color_t line_color);
        int gap;

        @(negedge clk);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {line_color, ye, xe, ys, xs};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.take_beat(op, xs, ys, xe, ye, line_color);
    endtask

    task automatic send_load(dlpg_pkg::coord_t xs, dlpg_pkg::coord_t ys,
                             dlpg_pkg::coord_t xe, dlpg_pkg::coord_t ye,
                             dlpg_pkg::color_t c);
        send_beat(dlpg_pkg::OP_LOAD, xs, ys, xe, ye, c);
    endtask

    // Step beats carry random payload; the block must ignore it.
    task automatic send_steps(int n);
        repeat (n)
            send_beat(dlpg_pkg::OP_STEP, dlpg_pkg::coord_t'($urandom),
                      dlpg_pkg::coord_t'($urandom), dlpg_pkg::coord_t'($urandom),
                      dlpg_pkg::coord_t'($urandom), $urandom);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Let all owed pixels drain, then allow for a divide still running on a load.
    task automatic settle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_width(dlpg_pkg::fwidth_t w);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {dlpg_pkg::REG_FRAME_WIDTH, 2'b00};
        pwdata  = 32'(w);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== 32'(w))
        begin
            $display("%0t: frame_width readback expected %h actual %h", $time, 32'(w), prdata);
            sb.errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        sb.frame_width = w;
    endtask

    function automatic dlpg_pkg::coord_t shift_coord(dlpg_pkg::coord_t base, int d);
        int v;

        v = int'(base) + d;
        if (v < 0 || v > 4095)
            v = int'(base) - d;
        return dlpg_pkg::coord_t'(v);
    endfunction

    task automatic random_traffic(int budget);
        int               sent;
        int               r;
        int               dx;
        int               dy;
        int               span;
        int               nsteps;
        dlpg_pkg::coord_t xs, ys, xe, ye;

        sent = 0;
        while (sent < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                send_steps(1);
                sent++;
                continue;
            end
            xs = dlpg_pkg::coord_t'($urandom_range(0, 4095));
            ys = dlpg_pkg::coord_t'($urandom_range(0, 4095));
            r  = $urandom_range(0, 99);
            if (r < 65)
            begin
                dx = $urandom_range(0, 24) - 12;
                dy = $urandom_range(0, 24) - 12;
            end
            else if (r < 80)
            begin
                // Axis-aligned and empty lines.
                dx = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 30) - 15;
                dy = (dx != 0) ? 0 : $urandom_range(0, 30) - 15;
            end
            else if (r < 95)
            begin
                dx = $urandom_range(0, 120) - 60;
                dy = $urandom_range(0, 120) - 60;
            end
            else
            begin
                dx = $urandom_range(0, 4095) - int'(xs);
                dy = $urandom_range(0, 4095) - int'(ys);
            end
            xe = shift_coord(xs, dx);
            ye = shift_coord(ys, dy);
            dx = (xs > xe) ? int'(xs - xe) : int'(xe - xs);
            dy = (ys > ye) ? int'(ys - ye) : int'(ye - ys);
            span = (dx > dy) ? dx : dy;
            if ($urandom_range(0, 4) != 0)
                nsteps = span + $urandom_range(0, 2);
            else
                nsteps = $urandom_range(0, span);
            if (nsteps > 48)
                nsteps = $urandom_range(20, 48);
            send_load(xs, ys, xe, ye, $urandom);
            send_steps(nsteps);
            sent += 1 + nsteps;
        end
        stop_sending();
    endtask

    initial
    begin : main
        dlpg_pkg::fwidth_t widths[6];
        int                ph;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = dlpg_pkg::OP_LOAD;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_en       = 1'b1;
        hold_req      = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed lines at the reset width.
        send_steps(1);
        send_load(12'd5, 12'd5, 12'd5, 12'd5, 32'h0000_0000);
        send_steps(1);
        send_load(12'd4095, 12'd4095, 12'd4095, 12'd4092, 32'hFFFF_FFFF);
        send_steps(3);
        send_load(12'd4095, 12'd7, 12'd4092, 12'd7, 32'hA5A5_A5A5);
        send_steps(3);
        send_load(12'd0, 12'd10, 12'd5, 12'd7, 32'h1234_5678);
        send_steps(5);
        send_load(12'd4095, 12'd0, 12'd0, 12'd4095, 32'h8000_0001);
        send_steps(2);
        send_load(12'd0, 12'd0, 12'd2, 12'd2, 32'h7FFF_FFFE);
        send_steps(3);
        stop_sending();

        widths[0] = 13'd1;
        widths[1] = 13'd4096;
        widths[2] = 13'd0;
        widths[3] = 13'd8191;
        widths[4] = dlpg_pkg::fwidth_t'($urandom_range(1, 4096));
        widths[5] = dlpg_pkg::fwidth_t'($urandom_range(1, 4096));
        for (ph = 0; ph < 6; ph++)
        begin
            settle();
            write_width(widths[ph]);
            if (ph == 0)
                hold_req = 1'b1;
            if (ph == 5)
                idle_en = 1'b0;
            random_traffic(320);
        end

        settle();
        if (sb.errors == 0)
            $display("dda_line_pixel_generator: match");
        else
            $display("dda_line_pixel_generator: mismatch");
        $finish;
    end

endmodule
